// ===== rtl/core/audio_jitter_buffer_latency_trim_macros.svh =====
// assertion macros used by the jitter buffer top module
// expects signals named clk and rst in the module that uses them
`ifndef AUDIO_JITTER_BUFFER_LATENCY_TRIM_MACROS_SVH
`define AUDIO_JITTER_BUFFER_LATENCY_TRIM_MACROS_SVH

// consequent must hold in the same cycle
`define AJB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define AJB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ajb_pkg.sv =====
// shared constants, types and helper functions for the jitter buffer
// no dependencies; imported by every module of the block except ajb_ram
`default_nettype none

package ajb_pkg;

  localparam int CHANNELS    = 8;
  localparam int DEPTH       = 32768;
  localparam int SAMPLE_BITS = 24;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ACT_W  = $clog2(CHANNELS + 1);
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = $clog2(2 * DEPTH + 1);
  localparam int RAM_AW = $clog2(CHANNELS * DEPTH);

  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int CNT_CFG_W = 4;
  localparam int GAIN_W    = 16;
  localparam int LAT_W     = 16;
  localparam int WIN_W     = 20;
  localparam int TRIM_W    = 16;
  localparam int TRIM_MAX  = 65535;
  localparam int CMP_W     = (FILL_W > LAT_W) ? FILL_W : LAT_W;

  localparam logic [CNT_CFG_W-1:0] CNT_RESET  = '0;
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd4096;
  localparam logic [LAT_W-1:0]     LAT_RESET  = 16'd882;
  localparam logic [WIN_W-1:0]     WIN_RESET  = 20'd132300;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    REG_CHANNELS     = 2'd0,
    REG_GAIN         = 2'd1,
    REG_MAX_LATENCY  = 2'd2,
    REG_CHECK_WINDOW = 2'd3
  } reg_idx_t;

  // one entry of the per-channel state memory
  typedef struct packed {
    logic [PTR_W-1:0]  wp;
    logic [PTR_W-1:0]  rp;
    logic [FILL_W-1:0] fill;
  } chan_st_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [GAIN_W-1:0] gain;
    logic [LAT_W-1:0]  max_latency;
    logic [WIN_W-1:0]  window;
    logic              trunc_en;
    logic [ACT_W-1:0]  trunc_act;
  } cfg_t;

  // channel count clamped to the number of rings
  function automatic logic [ACT_W-1:0] act_of(input logic [CNT_CFG_W-1:0] v);
    if (int'(v) > CHANNELS) begin
      return ACT_W'(CHANNELS);
    end
    return ACT_W'(v);
  endfunction

  function automatic logic [RAM_AW-1:0] ram_addr(input logic [CH_W-1:0] ch,
                                                 input logic [PTR_W-1:0] ptr);
    return RAM_AW'(ch) * RAM_AW'(DEPTH) + RAM_AW'(ptr);
  endfunction

  // ring pointer advance, k never above DEPTH
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                               input logic [FILL_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(ptr) + SUM_W'(k);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return PTR_W'(s);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ajb_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ajb_ram #(
  parameter int DATA_W = 24,
  parameter int ADDR_W = 18
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ajb_regs.sv =====
// apb configuration registers and the derived datapath configuration
// depends on ajb_pkg
`default_nettype none

module ajb_regs import ajb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [CNT_CFG_W-1:0] channels_in_use;
  logic [GAIN_W-1:0]    gain;
  logic [LAT_W-1:0]     max_latency;
  logic [WIN_W-1:0]     check_window;
  logic                 wr;
  reg_idx_t             idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CNT_RESET;
      gain            <= GAIN_RESET;
      max_latency     <= LAT_RESET;
      check_window    <= WIN_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_CHANNELS:     channels_in_use <= pwdata[CNT_CFG_W-1:0];
        REG_GAIN:         gain            <= pwdata[GAIN_W-1:0];
        REG_MAX_LATENCY:  max_latency     <= pwdata[LAT_W-1:0];
        REG_CHECK_WINDOW: check_window    <= pwdata[WIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHANNELS:     prdata = PDATA_W'(channels_in_use);
      REG_GAIN:         prdata = PDATA_W'(gain);
      REG_MAX_LATENCY:  prdata = PDATA_W'(max_latency);
      REG_CHECK_WINDOW: prdata = PDATA_W'(check_window);
    endcase
  end

  always_comb begin
    cfg.act         = act_of(channels_in_use);
    cfg.gain        = gain;
    cfg.max_latency = max_latency;
    // a zero window checks every frame
    cfg.window      = (check_window == '0) ? WIN_W'(1) : check_window;
    // rings at or above the new count are emptied on the same edge
    cfg.trunc_en    = wr && (idx == REG_CHANNELS);
    cfg.trunc_act   = act_of(pwdata[CNT_CFG_W-1:0]);
  end

endmodule

`default_nettype wire

// ===== rtl/core/ajb_gain.sv =====
// playback gain: registered q4.12 multiply, then round and saturate
// depends on ajb_pkg
`default_nettype none

module ajb_gain import ajb_pkg::*; (
  input  logic                          clk,
  input  logic                          en,
  input  logic [GAIN_W-1:0]             gain,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_W   = SAMPLE_BITS + GAIN_W + 1;
  localparam int FRAC     = 12;
  localparam int ROUND    = 2048;
  localparam int PASS_LO  = 4092;
  localparam int PASS_HI  = 4100;
  localparam int ZERO_MAX = 4;
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [1:0] {GM_SCALE, GM_PASS, GM_ZERO} gmode_t;

  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      rnd;
  logic signed [PROD_W-1:0]      quo;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic signed [SAMPLE_BITS-1:0] scaled;
  gmode_t                        mode;

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= sample * $signed({1'b0, gain});
      samp_q <= sample;
      if (gain >= GAIN_W'(PASS_LO) && gain <= GAIN_W'(PASS_HI)) begin
        mode <= GM_PASS;
      end else if (gain <= GAIN_W'(ZERO_MAX)) begin
        mode <= GM_ZERO;
      end else begin
        mode <= GM_SCALE;
      end
    end
  end

  // arithmetic shift floors, which gives ties toward plus infinity
  always_comb begin
    rnd = prod + $signed(PROD_W'(ROUND));
    quo = rnd >>> FRAC;
    if (quo > SAT_HI) begin
      scaled = SAT_HI[SAMPLE_BITS-1:0];
    end else if (quo < SAT_LO) begin
      scaled = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      scaled = quo[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    case (mode)
      GM_PASS: result = samp_q;
      GM_ZERO: result = '0;
      default: result = scaled;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/audio_jitter_buffer_latency_trim.sv =====
// Multichannel playback jitter buffer with latency trim.
// Input channel (in_valid/in_ready): operation 0 pushes sample_in into ring
// 'channel'; operation 1 reads one frame. Output channel (out_valid/out_ready)
// carries one word per active channel, in channel order, last on the final one.
// Configuration goes through the apb port; registers at byte 0, 4, 8 and 12.
// A push goes through S_PUSH, which writes the sample unless the ring is full.
// A read frame runs S_WIN once, then per channel S_CHAN, S_SMP (skipped when
// the channel is empty) and S_EMIT, which loads the output register. The pace
// is set by the read-modify-write of each channel's entry in the state memory
// followed by a sample memory read and the registered gain multiply.
// The output register holds a finished word while the sequencer keeps going;
// when the receiver stalls with that register full, the sequencer waits
// before loading the next word, and in_ready stays low until the frame ends.
// Reset empties every ring, clears the window and restores register defaults;
// sample memory contents are not cleared and need no clearing pass.
// depends on ajb_pkg, ajb_regs, ajb_ram, ajb_gain and the assertion macros
`default_nettype none
`include "audio_jitter_buffer_latency_trim_macros.svh"

module audio_jitter_buffer_latency_trim import ajb_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [2:0]                    channel,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_channel,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          underrun,
  output logic [TRIM_W-1:0]             trimmed_frames,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {S_IDLE, S_PUSH, S_WIN, S_CHAN, S_SMP, S_EMIT} state_t;

  cfg_t cfg;

  ajb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t                   state;
  logic [CH_W-1:0]          cur_ch;
  logic [CH_W-1:0]          push_ch;
  logic [SAMPLE_BITS-1:0]   push_data;
  logic [WIN_W-1:0]         window_count;
  logic [FILL_W-1:0]        min_fill;
  logic [FILL_W-1:0]        trim;
  logic                     res_under;

  // per-channel state memory, an entry that was never written reads as empty
  chan_st_t                 st_mem [CHANNELS];
  chan_st_t                 st_q;
  chan_st_t                 st_cur;
  chan_st_t                 st_wdata;
  logic [CHANNELS-1:0]      chan_vld;
  logic                     st_vld_q;
  logic                     st_re;
  logic                     st_we;
  logic [CH_W-1:0]          st_raddr;
  logic [CH_W-1:0]          st_waddr;

  logic                     ram_we;
  logic                     ram_re;
  logic [RAM_AW-1:0]        ram_waddr;
  logic [RAM_AW-1:0]        ram_raddr;
  logic [SAMPLE_BITS-1:0]   ram_rdata;
  logic signed [SAMPLE_BITS-1:0] gain_res;

  logic                     push_in_range;
  logic                     push_ok;
  logic [FILL_W-1:0]        k_trim;
  logic [FILL_W-1:0]        fill_trim;
  logic [PTR_W-1:0]         rp_trim;
  logic [PTR_W-1:0]         rp_after;
  logic                     has_data;
  logic [FILL_W-1:0]        mf_new;
  logic [WIN_W-1:0]         wc_new;
  logic                     win_close;
  logic                     over_lat;
  logic [FILL_W-1:0]        trim_new;
  logic [TRIM_W-1:0]        trim_sat;
  logic                     is_last;
  logic                     emit_go;

  assign in_ready      = (state == S_IDLE);
  assign st_cur        = st_vld_q ? st_q : '0;
  assign push_in_range = int'(channel) < int'(cfg.act);
  assign push_ok       = st_cur.fill < FILL_W'(DEPTH);

  // trim is applied before the frame's own sample is taken
  assign k_trim    = (trim < st_cur.fill) ? trim : st_cur.fill;
  assign fill_trim = st_cur.fill - k_trim;
  assign has_data  = fill_trim != '0;
  assign rp_trim   = ptr_add(st_cur.rp, k_trim);
  assign rp_after  = ptr_add(st_cur.rp, k_trim + FILL_W'(1));

  // window tracking on the fill of channel 0
  assign mf_new    = (window_count == '0) ? st_cur.fill :
                     ((st_cur.fill < min_fill) ? st_cur.fill : min_fill);
  assign wc_new    = (window_count == '0) ? WIN_W'(1) : window_count + WIN_W'(1);
  assign win_close = wc_new >= cfg.window;
  assign over_lat  = CMP_W'(mf_new) > CMP_W'(cfg.max_latency);
  assign trim_new  = FILL_W'(CMP_W'(mf_new) - CMP_W'(cfg.max_latency));

  assign trim_sat = (int'(trim) > TRIM_MAX) ? '1 : TRIM_W'(trim);
  assign is_last  = (ACT_W'(cur_ch) + ACT_W'(1)) == cfg.act;
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    st_re     = 1'b0;
    st_raddr  = cur_ch;
    st_we     = 1'b0;
    st_waddr  = cur_ch;
    st_wdata  = st_cur;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ram_addr(push_ch, st_cur.wp);
    ram_raddr = ram_addr(cur_ch, rp_trim);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == OP_PUSH) begin
            st_re    = push_in_range;
            st_raddr = CH_W'(channel);
          end else begin
            st_re    = cfg.act != '0;
            st_raddr = '0;
          end
        end
      end
      S_PUSH: begin
        st_waddr      = push_ch;
        st_wdata.wp   = ptr_add(st_cur.wp, FILL_W'(1));
        st_wdata.fill = st_cur.fill + FILL_W'(1);
        st_we         = push_ok;
        ram_we        = push_ok;
      end
      S_CHAN: begin
        st_we         = 1'b1;
        st_wdata.rp   = has_data ? rp_after : rp_trim;
        st_wdata.fill = has_data ? fill_trim - FILL_W'(1) : '0;
        ram_re        = has_data;
      end
      S_EMIT: begin
        if (emit_go && !is_last) begin
          st_re    = 1'b1;
          st_raddr = cur_ch + CH_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_q <= st_mem[st_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_vld <= '0;
      st_vld_q <= 1'b0;
    end else begin
      if (st_re) begin
        st_vld_q <= chan_vld[st_raddr];
      end
      if (st_we) begin
        chan_vld[st_waddr] <= 1'b1;
      end
      if (cfg.trunc_en) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (c >= int'(cfg.trunc_act)) begin
            chan_vld[c] <= 1'b0;
          end
        end
      end
    end
  end

  ajb_ram #(
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (RAM_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (push_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ajb_gain u_gain (
    .clk    (clk),
    .en     (state == S_SMP),
    .gain   (cfg.gain),
    .sample ($signed(ram_rdata)),
    .result (gain_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      window_count <= '0;
      min_fill     <= '0;
      trim         <= '0;
      cur_ch       <= '0;
    end else begin
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (operation == OP_PUSH) begin
              if (push_in_range) begin
                push_ch   <= CH_W'(channel);
                push_data <= sample_in;
                state     <= S_PUSH;
              end
            end else if (cfg.act != '0) begin
              cur_ch <= '0;
              state  <= S_WIN;
            end
          end
        end
        S_PUSH: begin
          state <= S_IDLE;
        end
        S_WIN: begin
          // st_q still holds channel 0, so the first channel needs no reread
          min_fill     <= mf_new;
          window_count <= win_close ? '0 : wc_new;
          trim         <= (win_close && over_lat) ? trim_new : '0;
          state        <= S_CHAN;
        end
        S_CHAN: begin
          res_under <= !has_data;
          state     <= has_data ? S_SMP : S_EMIT;
        end
        S_SMP: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid      <= 1'b1;
            out_channel    <= 3'(cur_ch);
            sample_out     <= res_under ? '0 : gain_res;
            underrun       <= res_under;
            trimmed_frames <= trim_sat;
            last           <= is_last;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              cur_ch <= cur_ch + CH_W'(1);
              state  <= S_CHAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AJB_ASSERT_NOW(a_st_no_overlap, st_we && st_re, st_waddr != st_raddr, "state memory read and write collide")
  `AJB_ASSERT_NOW(a_fill_range, st_vld_q, st_q.fill <= FILL_W'(DEPTH), "ring fill beyond depth")
  `AJB_ASSERT_NOW(a_under_zero, out_valid && underrun, sample_out == '0, "underrun word carries data")
  `AJB_ASSERT_NEXT(a_trim_at_close, state == S_WIN, (trim == '0) || (window_count == '0), "trim outside window close")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the multichannel jitter buffer with latency trim
// drives push and read words plus apb register writes, predicts and checks every output word
// depends on ajb_pkg and audio_jitter_buffer_latency_trim
module tb_top;
  import ajb_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [2:0]        chan;
    sample_t           value;
    logic              empty;
    logic [TRIM_W-1:0] trimmed;
    logic              tail;
  } word_t;

  localparam int IDLE_PCT      = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_WORDS  = 60;
  localparam sample_t SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = OP_PUSH;
  logic [2:0]         channel = '0;
  sample_t            sample_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_channel;
  sample_t            sample_out;
  logic               underrun;
  logic [TRIM_W-1:0]  trimmed_frames;
  logic               last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // buffer state as the predictor sees it
  logic [CNT_CFG_W-1:0] cnt_cfg = CNT_RESET;
  logic [GAIN_W-1:0]    gain_cfg = GAIN_RESET;
  logic [LAT_W-1:0]     lat_cfg = LAT_RESET;
  logic [WIN_W-1:0]     win_cfg = WIN_RESET;
  logic [WIN_W-1:0]     win_count = '0;
  int unsigned          low_fill = 0;
  sample_t              ring_q [CHANNELS][$];
  word_t                frame_words [$];

  bit     steady_in = 1'b0;
  bit     steady_out = 1'b0;
  int     mismatches = 0;
  int     words_sent = 0;
  int     words_checked = 0;
  int     reg_writes = 0;
  longint cycles = 0;

  audio_jitter_buffer_latency_trim u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .channel        (channel),
    .sample_in      (sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .sample_out     (sample_out),
    .underrun       (underrun),
    .trimmed_frames (trimmed_frames),
    .last           (last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk = ~clk;

  function automatic int unsigned active_chans();
    return (int'(cnt_cfg) > CHANNELS) ? CHANNELS : int'(cnt_cfg);
  endfunction

  function automatic sample_t gain_scale(sample_t s);
    longint hi;
    longint lo;
    longint p;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (gain_cfg >= 16'd4092 && gain_cfg <= 16'd4100) return s;
    if (gain_cfg <= 16'd4) return '0;
    // half-step offset then floor rounds ties upward
    p = (longint'(s) * longint'({1'b0, gain_cfg}) + 2048) >>> 12;
    if (p > hi) p = hi;
    if (p < lo) p = lo;
    return sample_t'(p);
  endfunction

  function automatic void play_item(logic op, logic [2:0] ch, sample_t smp);
    int unsigned n;
    int unsigned span;
    int unsigned trim;
    int unsigned k;
    word_t w;
    n = active_chans();
    if (op == OP_PUSH) begin
      if (ch < n && ring_q[ch].size() < DEPTH) ring_q[ch].push_back(smp);
      return;
    end
    if (n == 0) return;
    // minimum fill of channel 0 over the window
    if (win_count == 0) begin
      low_fill = ring_q[0].size();
      win_count = 1;
    end else begin
      if (ring_q[0].size() < low_fill) low_fill = ring_q[0].size();
      win_count = win_count + 1'b1;
    end
    span = (win_cfg == 0) ? 1 : win_cfg;
    trim = 0;
    if (win_count >= span) begin
      win_count = '0;
      if (low_fill > lat_cfg) begin
        trim = low_fill - lat_cfg;
        for (int c = 0; c < n; c++) begin
          k = (trim < ring_q[c].size()) ? trim : ring_q[c].size();
          repeat (k) void'(ring_q[c].pop_front());
        end
      end
    end
    for (int c = 0; c < n; c++) begin
      w.chan = 3'(c);
      w.empty = (ring_q[c].size() == 0);
      if (w.empty) begin
        w.value = '0;
      end else begin
        w.value = gain_scale(ring_q[c].pop_front());
      end
      w.trimmed = (trim > TRIM_MAX) ? TRIM_W'(TRIM_MAX) : TRIM_W'(trim);
      w.tail = (c == n - 1);
      frame_words.push_back(w);
    end
  endfunction

  task automatic send_word(logic op, logic [2:0] ch, sample_t smp);
    if (!steady_in) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    operation <= op;
    channel <= ch;
    sample_in <= smp;
    do @(posedge clk); while (!in_ready);
    play_item(op, ch, smp);
    words_sent++;
  endtask

  task automatic push_sample(logic [2:0] ch, sample_t smp);
    send_word(OP_PUSH, ch, smp);
  endtask

  // channel and sample are don't-care on a read, so they carry noise
  task automatic read_frame();
    send_word(OP_READ, 3'($urandom), sample_t'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frame_words.size() != 0) @(posedge clk);
    // a trailing push leaves nothing to wait for, so give it time to land
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [PDATA_W-1:0] v);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(int'(idx) * 4);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
    case (idx)
      REG_CHANNELS: begin
        cnt_cfg = v[CNT_CFG_W-1:0];
        for (int c = active_chans(); c < CHANNELS; c++) ring_q[c].delete();
      end
      REG_GAIN:         gain_cfg = v[GAIN_W-1:0];
      REG_MAX_LATENCY:  lat_cfg = v[LAT_W-1:0];
      REG_CHECK_WINDOW: win_cfg = v[WIN_W-1:0];
      default: ;
    endcase
  endtask

  // output side: random stalls, compare each accepted word, cycle limit
  always @(posedge clk) begin
    word_t got;
    word_t w;
    cycles++;
    if (!rst && out_valid && out_ready) begin
      got = {out_channel, sample_out, underrun, trimmed_frames, last};
      if (frame_words.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected output word at cycle %0d: ch %0d sample %0d", cycles,
                   got.chan, got.value);
        end
        mismatches++;
      end else begin
        w = frame_words.pop_front();
        words_checked++;
        if (got.chan !== w.chan || got.value !== w.value || got.empty !== w.empty ||
            got.trimmed !== w.trimmed || got.tail !== w.tail) begin
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch at cycle %0d: expected ch %0d sample %0d underrun %0b trim %0d last %0b",
                     cycles, w.chan, w.value, w.empty, w.trimmed, w.tail);
            $display("  got ch %0d sample %0d underrun %0b trim %0d last %0b",
                     got.chan, got.value, got.empty, got.trimmed, got.tail);
          end
          mismatches++;
        end
      end
    end
    out_ready <= steady_out || ($urandom_range(99) >= IDLE_PCT);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // after reset no channel is active: pushes vanish, reads give nothing
  task automatic test_idle_defaults();
    push_sample(3'd0, SMP_MAX);
    push_sample(3'd7, SMP_MIN);
    read_frame();
    read_frame();
  endtask

  task automatic test_basic_frames();
    sample_t pats [8];
    pats = '{SMP_MAX, SMP_MIN, sample_t'(0), sample_t'(-1), sample_t'(1),
             sample_t'(24'h555555), sample_t'(24'hAAAAAA), sample_t'($urandom)};
    set_reg(REG_CHANNELS, 8);
    set_reg(REG_MAX_LATENCY, 32768);
    set_reg(REG_CHECK_WINDOW, 20'hFFFFF);
    for (int c = 0; c < CHANNELS; c++) push_sample(3'(c), pats[c]);
    read_frame();
    read_frame();
    push_sample(3'd7, SMP_MIN);
    read_frame();
  endtask

  // pass-through band, near-zero band and scaled region on both sides
  task automatic test_gain_paths();
    logic [GAIN_W-1:0] gain_pts [9];
    gain_pts = '{16'd0, 16'd4, 16'd5, 16'd2048, 16'd4091, 16'd4092, 16'd4100,
                 16'd4101, 16'hFFFF};
    set_reg(REG_CHANNELS, 2);
    foreach (gain_pts[i]) begin
      set_reg(REG_GAIN, gain_pts[i]);
      push_sample(3'd0, (i % 2 == 0) ? SMP_MAX : sample_t'($urandom));
      push_sample(3'd1, (i % 2 == 0) ? SMP_MIN : sample_t'(-1));
      read_frame();
      // underrun flag must still show when gain forces zeros
      if (gain_pts[i] <= 16'd4) read_frame();
    end
  endtask

  task automatic test_channel_count();
    set_reg(REG_GAIN, 16'd4096);
    set_reg(REG_CHANNELS, 15);
    for (int c = 0; c < CHANNELS; c++) push_sample(3'(c), sample_t'($urandom));
    read_frame();
    for (int c = 0; c < CHANNELS; c++) push_sample(3'(c), sample_t'($urandom));
    // shrinking empties the rings above the new count
    set_reg(REG_CHANNELS, 3);
    read_frame();
    set_reg(REG_CHANNELS, 8);
    read_frame();
    set_reg(REG_CHANNELS, 0);
    push_sample(3'd0, SMP_MAX);
    read_frame();
  endtask

  task automatic test_latency_trim();
    set_reg(REG_CHANNELS, 2);
    set_reg(REG_MAX_LATENCY, 3);
    set_reg(REG_CHECK_WINDOW, 4);
    repeat (12) push_sample(3'd0, sample_t'($urandom));
    repeat (2) push_sample(3'd1, sample_t'($urandom));
    repeat (6) read_frame();
    // zero window behaves as a check on every frame
    set_reg(REG_CHECK_WINDOW, 0);
    set_reg(REG_MAX_LATENCY, 0);
    repeat (5) push_sample(3'd0, sample_t'($urandom));
    push_sample(3'd1, sample_t'($urandom));
    read_frame();
    read_frame();
  endtask

  task automatic test_random_traffic();
    int useful;
    int phase;
    int unsigned n;
    logic [2:0] ch;
    sample_t s;
    logic [GAIN_W-1:0] g;
    useful = 0;
    phase = 0;
    while (useful < RANDOM_WORDS) begin
      n = $urandom_range(19);
      set_reg(REG_CHANNELS, (n == 0) ? 0 : (n == 1) ? $urandom_range(15, 9) : $urandom_range(8, 1));
      case ($urandom_range(5))
        0:       g = GAIN_W'($urandom_range(4));
        1:       g = GAIN_W'($urandom_range(4100, 4092));
        2:       g = 16'hFFFF;
        3:       g = GAIN_W'($urandom_range(4091, 5));
        default: g = GAIN_W'($urandom_range(65534, 4101));
      endcase
      set_reg(REG_GAIN, g);
      case ($urandom_range(7))
        0:       set_reg(REG_MAX_LATENCY, 32768);
        1:       set_reg(REG_MAX_LATENCY, 16'($urandom));
        default: set_reg(REG_MAX_LATENCY, $urandom_range(6));
      endcase
      case ($urandom_range(7))
        0:       set_reg(REG_CHECK_WINDOW, 20'hFFFFF);
        1:       set_reg(REG_CHECK_WINDOW, 20'($urandom));
        default: set_reg(REG_CHECK_WINDOW, $urandom_range(6));
      endcase
      // one phase runs with no idling on either side
      steady_in = (phase == 2);
      steady_out = (phase == 2);
      n = active_chans();
      repeat (25) begin
        if ($urandom_range(99) < 35) begin
          read_frame();
          if (n > 0) useful++;
        end else begin
          ch = (n > 0 && $urandom_range(99) < 85) ? 3'($urandom_range(n - 1)) : 3'($urandom);
          case ($urandom_range(9))
            0:       s = SMP_MAX;
            1:       s = SMP_MIN;
            2:       s = '0;
            default: s = sample_t'($urandom);
          endcase
          push_sample(ch, s);
          if (ch < n) useful++;
        end
      end
      phase++;
    end
    steady_in = 1'b0;
    steady_out = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_defaults();
    test_basic_frames();
    test_gain_paths();
    test_channel_count();
    test_latency_trim();
    test_random_traffic();
    wait_idle();
    if (frame_words.size() != 0) begin
      $display("%0d expected output words never arrived", frame_words.size());
      mismatches += frame_words.size();
    end
    $display("drove %0d input words and %0d register writes, checked %0d output words",
             words_sent, reg_writes, words_checked);
    $display("covered gain bands, channel count changes, underruns and latency trims");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
